// ===== sv/bsg_pkg.sv =====
`default_nettype none
package bsg_pkg;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_ADD_PT = 2'd1,
    CMD_ADD_SP = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_RR,
    S_SQ,
    S_ROOT,
    S_PLAN,
    S_MMUL,
    S_MDIV,
    S_MADD,
    S_FIN
  } state_e;

endpackage
`default_nettype wire

// ===== sv/bounding_sphere_grow.sv =====
// Result path: S_DIFF, S_RR, S_SQ, S_ROOT, S_PLAN, then S_MMUL, S_MDIV, S_MADD per axis
//   when the sphere is moved, and S_FIN; CB = COORD_BITS.
// One transaction in flight; s_axis_tready rises with m_axis_tvalid when the result
//   is registered, after any wait for a held result. The bit-serial multiplier,
//   square root and divider take one bit (root: two) per cycle.
// Reset: sphere center and radius cleared, no result pending.
`default_nettype none
module bounding_sphere_grow import bsg_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      s_axis_tvalid,
  output logic                                     s_axis_tready,
  // point_x, point_y, point_z, in_radius
  input  wire  [((4*COORD_BITS-1+7)/8)*8-1:0]      s_axis_tdata,
  // cmd
  input  wire  [1:0]                               s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  // center_x, center_y, center_z, out_radius, grew
  output logic [((4*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int CB   = COORD_BITS;
  localparam int OTW  = ((4*CB+7)/8)*8;
  localparam int MBW  = CB+2;
  localparam int PW   = 2*CB+4;
  localparam int DW   = CB+2;
  localparam int RW   = CB+5;
  localparam int DENW = CB+3;
  localparam int EW   = CB+3;
  localparam int SW   = CB+2;
  localparam int CW   = $clog2(PW+1);

  state_e st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      idx_q, idx_d;
  logic            ov_q, ov_d;
  logic [CB-1:0]   cen_q [3];
  logic [CB-1:0]   cen_d [3];
  logic [CB-2:0]   rad_q, rad_d;
  logic            chg_q, chg_d;

  logic [CB-1:0]   p_q [3];
  logic [CB-1:0]   p_d [3];
  logic [CB-2:0]   r2_q, r2_d;
  cmd_e            cmd_q, cmd_d;
  logic [CB:0]     mag_q [3];
  logic [CB:0]     mag_d [3];
  logic            sgn_q [3];
  logic            sgn_d [3];
  logic [PW-1:0]   rr_q, rr_d, acc_q, acc_d, ma_q, ma_d, sh_q, sh_d;
  logic [MBW-1:0]  mb_q, mb_d, num_q, num_d;
  logic [DW-1:0]   root_q, root_d, d_q, d_d;
  logic [RW-1:0]   srem_q, srem_d;
  logic [DENW-1:0] den_q, den_d, drem_q, drem_d;
  logic [CB:0]     quo_q, quo_d;
  logic            outside_q, outside_d;
  logic [OTW-1:0]  od_q, od_d;

  logic [PW-1:0]   acc_step;
  logic [RW-1:0]   sq_x, sq_t, sq_rem;
  logic [DW-1:0]   sq_root;
  logic [DENW:0]   dv_x;
  logic [DENW-1:0] dv_rem;
  logic [CB:0]     dv_quo;
  logic [1:0]      sel;
  logic [CB:0]     mag_sel;
  logic [CB:0]     dxv [3];
  logic [EW-1:0]   r_e, r2_e, d_e, nr1, nr2, num1, span, rmax_e;
  logic signed [SW-1:0] mv, sum, cmax, cmin;
  logic [CB-1:0]   newc;
  logic            mul_last, root_last, div_last;

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  assign acc_step  = acc_q + (mb_q[0] ? ma_q : '0);
  assign sq_x      = {srem_q[RW-3:0], sh_q[PW-1 -: 2]};
  assign sq_t      = {{(RW-DW-2){1'b0}}, root_q, 2'b01};
  assign sq_rem    = (sq_x >= sq_t) ? sq_x - sq_t : sq_x;
  assign sq_root   = {root_q[DW-2:0], sq_x >= sq_t};
  assign dv_x      = {drem_q, acc_q[PW-1]};
  assign dv_rem    = (dv_x >= {1'b0, den_q}) ? DENW'(dv_x - {1'b0, den_q}) : dv_x[DENW-1:0];
  assign dv_quo    = {quo_q[CB-1:0], dv_x >= {1'b0, den_q}};
  assign mul_last  = (cnt_q == CW'(MBW-1));
  assign root_last = (cnt_q == CW'(PW/2-1));
  assign div_last  = (cnt_q == CW'(PW-1));

  assign sel     = (st_q == S_SQ || st_q == S_MADD) ? idx_q + 2'd1 : idx_q;
  assign mag_sel = (sel == 2'd2) ? mag_q[2] : (sel == 2'd1) ? mag_q[1] : mag_q[0];

  assign r_e    = EW'(rad_q);
  assign r2_e   = EW'(r2_q);
  assign d_e    = EW'(d_q);
  assign rmax_e = EW'({(CB-1){1'b1}});
  assign nr1    = (d_e + r_e + EW'(1)) >> 1;
  assign num1   = nr1 - r_e;
  assign nr2    = (r_e + r2_e + d_e + EW'(1)) >> 1;
  assign span   = r2_e + d_e - r_e;

  assign cmax = $signed({3'b000, {(CB-1){1'b1}}});
  assign cmin = $signed({{3{1'b1}}, {(CB-1){1'b0}}});
  assign mv   = sgn_q[idx_q] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum  = $signed({{2{cen_q[idx_q][CB-1]}}, cen_q[idx_q]}) + mv;
  assign newc = (sum > cmax) ? cmax[CB-1:0] : (sum < cmin) ? cmin[CB-1:0] : sum[CB-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dxv[i] = {p_q[i][CB-1], p_q[i]} - {cen_q[i][CB-1], cen_q[i]};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (s_axis_tvalid) st_d = S_DIFF;
      S_DIFF: st_d = S_RR;
      S_RR:   if (mul_last) st_d = S_SQ;
      S_SQ:   if (mul_last && idx_q == 2'd2) st_d = S_ROOT;
      S_ROOT: if (root_last) st_d = S_PLAN;
      S_PLAN: begin
        if ((cmd_q == CMD_ADD_PT && outside_q) ||
            (cmd_q == CMD_ADD_SP && !(r2_e > r_e && d_e < r2_e - r_e) && r2_e + d_e > r_e))
          st_d = S_MMUL;
        else
          st_d = S_FIN;
      end
      S_MMUL: if (mul_last) st_d = S_MDIV;
      S_MDIV: if (div_last) st_d = S_MADD;
      S_MADD: st_d = (idx_q == 2'd2) ? S_FIN : S_MMUL;
      S_FIN:  if (!ov_q || m_axis_tready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; cen_d = cen_q; rad_d = rad_q; chg_d = chg_q;
    p_d = p_q; r2_d = r2_q; cmd_d = cmd_q; mag_d = mag_q; sgn_d = sgn_q;
    rr_d = rr_q; acc_d = acc_q; ma_d = ma_q; mb_d = mb_q; sh_d = sh_q; num_d = num_q;
    root_d = root_q; d_d = d_q; srem_d = srem_q; den_d = den_q; drem_d = drem_q;
    quo_d = quo_q; outside_d = outside_q; od_d = od_q;
    ov_d = (ov_q && m_axis_tready) ? 1'b0 : ov_q;
    unique case (st_q)
      S_IDLE: begin
        p_d[0] = s_axis_tdata[CB-1:0];
        p_d[1] = s_axis_tdata[2*CB-1:CB];
        p_d[2] = s_axis_tdata[3*CB-1:2*CB];
        r2_d   = s_axis_tdata[4*CB-2:3*CB];
        cmd_d  = cmd_e'(s_axis_tuser);
        chg_d  = 1'b0;
      end
      S_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          sgn_d[i] = dxv[i][CB];
          mag_d[i] = dxv[i][CB] ? -dxv[i] : dxv[i];
        end
        acc_d = '0; ma_d = PW'(rad_q); mb_d = MBW'(rad_q); cnt_d = '0; idx_d = 2'd0;
      end
      S_RR: begin
        acc_d = acc_step; ma_d = ma_q << 1; mb_d = mb_q >> 1; cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          rr_d = acc_step; acc_d = '0; ma_d = PW'(mag_q[0]); mb_d = MBW'(mag_q[0]);
          cnt_d = '0;
        end
      end
      S_SQ: begin
        acc_d = acc_step; ma_d = ma_q << 1; mb_d = mb_q >> 1; cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          cnt_d = '0;
          if (idx_q == 2'd2) begin
            outside_d = acc_step > rr_q;
            sh_d = acc_step; srem_d = '0; root_d = '0; idx_d = 2'd0;
          end else begin
            idx_d = idx_q + 2'd1; ma_d = PW'(mag_sel); mb_d = MBW'(mag_sel);
          end
        end
      end
      S_ROOT: begin
        sh_d = sh_q << 2; srem_d = sq_rem; root_d = sq_root; cnt_d = cnt_q + CW'(1);
        if (root_last) begin
          d_d = sq_root + DW'(sq_rem != '0);
          cnt_d = '0;
        end
      end
      S_PLAN: begin
        acc_d = '0; ma_d = PW'(mag_sel); cnt_d = '0;
        unique case (cmd_q)
          CMD_START: begin
            cen_d = p_q; rad_d = r2_q;
            chg_d = (p_q[0] != cen_q[0]) || (p_q[1] != cen_q[1]) ||
                    (p_q[2] != cen_q[2]) || (r2_q != rad_q);
          end
          CMD_ADD_PT: begin
            if (outside_q) begin
              rad_d = (nr1 > rmax_e) ? {(CB-1){1'b1}} : nr1[CB-2:0];
              chg_d = (rad_d != rad_q);
              num_d = MBW'(num1); mb_d = MBW'(num1); den_d = DENW'(d_q);
            end
          end
          CMD_ADD_SP: begin
            if (r2_e > r_e && d_e < r2_e - r_e) begin
              cen_d = p_q; rad_d = r2_q;
              chg_d = (p_q[0] != cen_q[0]) || (p_q[1] != cen_q[1]) ||
                      (p_q[2] != cen_q[2]) || (r2_q != rad_q);
            end else if (r2_e + d_e > r_e) begin
              rad_d = (nr2 > rmax_e) ? {(CB-1){1'b1}} : nr2[CB-2:0];
              chg_d = (rad_d != rad_q);
              num_d = MBW'(span); mb_d = MBW'(span); den_d = {d_q, 1'b0};
            end
          end
          default: ;
        endcase
      end
      S_MMUL: begin
        acc_d = acc_step; ma_d = ma_q << 1; mb_d = mb_q >> 1; cnt_d = cnt_q + CW'(1);
        if (mul_last) begin
          cnt_d = '0; drem_d = '0; quo_d = '0;
        end
      end
      S_MDIV: begin
        acc_d = acc_q << 1; drem_d = dv_rem; quo_d = dv_quo; cnt_d = cnt_q + CW'(1);
        if (div_last) cnt_d = '0;
      end
      S_MADD: begin
        cen_d[idx_q] = newc;
        if (newc != cen_q[idx_q]) chg_d = 1'b1;
        idx_d = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
        acc_d = '0; ma_d = PW'(mag_sel); mb_d = num_q; cnt_d = '0;
      end
      S_FIN: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          od_d = OTW'({chg_q, rad_q, cen_q[2], cen_q[1], cen_q[0]});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
      rad_q  <= '0;
      chg_q  <= 1'b0;
      for (int i = 0; i < 3; i++) cen_q[i] <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
      rad_q <= rad_d;
      chg_q <= chg_d;
      cen_q <= cen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; r2_q <= r2_d; cmd_q <= cmd_d; mag_q <= mag_d; sgn_q <= sgn_d;
    rr_q <= rr_d; acc_q <= acc_d; ma_q <= ma_d; mb_q <= mb_d; sh_q <= sh_d;
    num_q <= num_d; root_q <= root_d; d_q <= d_d; srem_q <= srem_d;
    den_q <= den_d; drem_q <= drem_d; quo_q <= quo_d; outside_q <= outside_d;
    od_q <= od_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(PW)) else $error("bit counter out of range");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= 2'd2) else $error("component index out of range");
  a_inside_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PLAN && cmd_q == CMD_ADD_PT && !outside_q) |=> $stable(rad_q))
    else $error("radius changed for inside point");
  a_dist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PLAN && cmd_q == CMD_ADD_PT && outside_q) |-> d_q != '0)
    else $error("zero distance for outside point");
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> st_q == S_DIFF)
    else $error("accepted transaction not started");

endmodule
`default_nettype wire
